FILE: rtl/gbe_pkg.sv
package gbe_pkg;

   // default widths of the rate path
   localparam int RATE_WIDTH_DEFAULT    = 24;
   localparam int GAIN_FRACTION_DEFAULT = 32;

   // fixed register and field widths
   localparam int LIMIT_WIDTH     = 23;
   localparam int FRAMES_WIDTH    = 16;
   localparam int COUNT_WIDTH     = 10;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int AXES            = 3;

   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [LIMIT_WIDTH-1:0]  limit_type;
   typedef logic [FRAMES_WIDTH-1:0] frames_type;

   // register map
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LINEAR_LIMIT = 3'd0,
      CSR_TURN_LIMIT   = 3'd1,
      CSR_STILL_FRAMES = 3'd2,
      CSR_LOCK_COUNT   = 3'd3,
      CSR_TRACK_GAIN   = 3'd4
   } csr_index_type;

   // item kinds
   localparam logic MODE_ODOMETRY = 1'b0;
   localparam logic MODE_GYRO     = 1'b1;

   // register values after reset
   localparam limit_type                 LINEAR_LIMIT_RESET = 23'd3277;
   localparam limit_type                 TURN_LIMIT_RESET   = 23'd3277;
   localparam frames_type                STILL_FRAMES_RESET = 16'd10;
   localparam count_type                 LOCK_COUNT_RESET   = 10'd200;
   localparam logic [CSR_DATA_WIDTH-1:0] TRACK_GAIN_RESET   = 32'd85899;

endpackage

FILE: rtl/gbe_div.sv
module gbe_div #(
   parameter int RATE_WIDTH = gbe_pkg::RATE_WIDTH_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              start,
   input  logic signed [RATE_WIDTH+gbe_pkg::COUNT_WIDTH-1:0] dividend,
   input  gbe_pkg::count_type                                divisor,
   output logic                                              done,
   output logic signed [RATE_WIDTH-1:0]                      quotient
);
   import gbe_pkg::*;

   localparam int SUM_WIDTH  = RATE_WIDTH + COUNT_WIDTH;
   localparam int STEP_WIDTH = $clog2(SUM_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [SUM_WIDTH-1:0]  shift_ff, shift_in;
   count_type             rem_ff, rem_in;
   count_type             divisor_ff, divisor_in;
   logic                  neg_ff, neg_in;

   logic [COUNT_WIDTH:0]  trial;
   logic [COUNT_WIDTH:0]  trial_diff;
   logic                  fits;
   logic [RATE_WIDTH-1:0] mag_quot;

   // restoring divide, one quotient bit per cycle, dividend bits leave at the top
   always_comb begin
      trial      = {rem_ff, shift_ff[SUM_WIDTH-1]};
      trial_diff = trial - {1'b0, divisor_ff};
      fits       = (trial >= {1'b0, divisor_ff});

      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;

      if (start) begin
         busy_in    = 1'b1;
         step_in    = STEP_WIDTH'(SUM_WIDTH);
         shift_in   = dividend[SUM_WIDTH-1] ? -dividend : dividend;
         rem_in     = '0;
         divisor_in = divisor;
         neg_in     = dividend[SUM_WIDTH-1];
      end else if (busy_ff) begin
         shift_in = {shift_ff[SUM_WIDTH-2:0], fits};
         rem_in   = fits ? trial_diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
         step_in  = step_ff - 1'b1;
         if (step_ff == STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // operands
   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
   end

   // quotient magnitude fits the rate width, sign restored here
   assign mag_quot = shift_ff[RATE_WIDTH-1:0];
   assign quotient = neg_ff ? -mag_quot : mag_quot;
   assign done     = done_ff;

endmodule

FILE: rtl/gbe_mul.sv
module gbe_mul #(
   parameter int RATE_WIDTH    = gbe_pkg::RATE_WIDTH_DEFAULT,
   parameter int GAIN_FRACTION = gbe_pkg::GAIN_FRACTION_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic signed [RATE_WIDTH+GAIN_FRACTION:0]    operand,
   input  logic [GAIN_FRACTION-1:0]                    gain,
   output logic                                        done,
   output logic signed [RATE_WIDTH+GAIN_FRACTION:0]    product
);
   import gbe_pkg::*;

   localparam int DIFF_WIDTH = RATE_WIDTH + GAIN_FRACTION + 1;
   localparam int STEP_WIDTH = $clog2(GAIN_FRACTION + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;
   logic [GAIN_FRACTION-1:0] gain_sh_ff, gain_sh_in;
   logic [DIFF_WIDTH-1:0]    operand_ff, operand_in;
   logic [DIFF_WIDTH-1:0]    acc_ff, acc_in;
   logic [DIFF_WIDTH:0]      sum_wide;

   // shift-add over gain bits, lsb first; each halving drops a bit, so the
   // result is the floor of gain * operand / 2^GAIN_FRACTION
   always_comb begin
      sum_wide = {acc_ff[DIFF_WIDTH-1], acc_ff}
               + (gain_sh_ff[0] ? {operand_ff[DIFF_WIDTH-1], operand_ff} : '0);

      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      gain_sh_in = gain_sh_ff;
      operand_in = operand_ff;
      acc_in     = acc_ff;

      if (start) begin
         busy_in    = 1'b1;
         step_in    = STEP_WIDTH'(GAIN_FRACTION);
         gain_sh_in = gain;
         operand_in = operand;
         acc_in     = '0;
      end else if (busy_ff) begin
         gain_sh_in = gain_sh_ff >> 1;
         acc_in     = sum_wide[DIFF_WIDTH:1];
         step_in    = step_ff - 1'b1;
         if (step_ff == STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // operands and accumulator
   always_ff @(posedge clock) begin
      gain_sh_ff <= gain_sh_in;
      operand_ff <= operand_in;
      acc_ff     <= acc_in;
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

FILE: rtl/gyro_bias_estimator.sv
// channel   direction  handshake                 payload
// req       in         req_valid / req_stall     mode, speeds, gyro rates
// rsp       out        rsp_valid / rsp_stall     corrected rates, locked, still
// csr       in         csr_write                 csr_index, csr_wdata
//
// an odometry item is taken in S_IDLE; a gyro item outside sampling passes S_JUDGE and S_OUT
// a tracked sample passes S_JUDGE, S_MUL and S_OUT, paced by the serial gain multiplier
// the locking sample passes S_JUDGE, S_DIV and S_OUT, paced by the serial mean divider
// reset is synchronous and clears control and the running sums; no clearing pass
// an item is taken while a result waits in rsp; a stalled rsp holds its fields
module gyro_bias_estimator #(
   parameter int RATE_WIDTH    = gbe_pkg::RATE_WIDTH_DEFAULT,
   parameter int GAIN_FRACTION = gbe_pkg::GAIN_FRACTION_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic signed [RATE_WIDTH-1:0]          req_linear_speed,
   input  logic signed [RATE_WIDTH-1:0]          req_yaw_speed,
   input  logic signed [RATE_WIDTH-1:0]          req_rate_x,
   input  logic signed [RATE_WIDTH-1:0]          req_rate_y,
   input  logic signed [RATE_WIDTH-1:0]          req_rate_z,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [RATE_WIDTH-1:0]          rsp_fixed_x,
   output logic signed [RATE_WIDTH-1:0]          rsp_fixed_y,
   output logic signed [RATE_WIDTH-1:0]          rsp_fixed_z,
   output logic                                  rsp_bias_locked,
   output logic                                  rsp_is_still,

   input  logic                                  csr_write,
   input  logic [gbe_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [gbe_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import gbe_pkg::*;

   localparam int SUM_WIDTH  = RATE_WIDTH + COUNT_WIDTH;
   localparam int BIAS_WIDTH = RATE_WIDTH + GAIN_FRACTION;
   localparam int DIFF_WIDTH = BIAS_WIDTH + 1;
   localparam int WIDE_WIDTH = RATE_WIDTH + 2;
   localparam int CMP_WIDTH  = (RATE_WIDTH > LIMIT_WIDTH) ? RATE_WIDTH : LIMIT_WIDTH;
   localparam logic [GAIN_FRACTION-1:0] ROUND_HALF = {1'b1, {(GAIN_FRACTION-1){1'b0}}};
   localparam logic [RATE_WIDTH-1:0] RATE_MAX = {1'b0, {(RATE_WIDTH-1){1'b1}}};
   localparam logic [RATE_WIDTH-1:0] RATE_MIN = {1'b1, {(RATE_WIDTH-1){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_JUDGE,
      S_DIV,
      S_MUL,
      S_OUT
   } state_type;

   // control and configuration
   state_type                 state_ff, state_in;
   limit_type                 lin_limit_ff, lin_limit_in;
   limit_type                 turn_limit_ff, turn_limit_in;
   frames_type                frames_ff, frames_in;
   count_type                 lock_count_ff, lock_count_in;
   logic [GAIN_FRACTION-1:0]  gain_ff, gain_in;
   logic                      odo_seen_ff, odo_seen_in;
   frames_type                still_run_ff, still_run_in;
   count_type                 sum_count_ff, sum_count_in;
   logic                      locked_ff, locked_in;
   logic                      still_ff, still_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_WIDTH-1:0] sum_ff [AXES];
   logic signed [SUM_WIDTH-1:0] sum_in [AXES];

   // payload
   logic signed [RATE_WIDTH-1:0] last_linear_ff, last_linear_in;
   logic signed [RATE_WIDTH-1:0] last_yaw_ff, last_yaw_in;
   logic signed [RATE_WIDTH-1:0] x_ff [AXES];
   logic signed [RATE_WIDTH-1:0] x_in [AXES];
   logic signed [BIAS_WIDTH-1:0] bias_ff [AXES];
   logic signed [BIAS_WIDTH-1:0] bias_in [AXES];
   logic signed [RATE_WIDTH-1:0] rsp_fixed_ff [AXES];
   logic signed [RATE_WIDTH-1:0] rsp_fixed_in [AXES];
   logic                         rsp_locked_ff, rsp_locked_in;
   logic                         rsp_still_ff, rsp_still_in;

   // datapath between registers
   logic                         accept;
   logic [RATE_WIDTH-1:0]        mag_lin;
   logic [RATE_WIDTH-1:0]        mag_yaw;
   logic                         still;
   frames_type                   run_next;
   logic                         sampling;
   count_type                    count_inc;
   logic                         lock_now;
   count_type                    divisor;
   logic                         div_start;
   logic                         mul_start;
   logic [AXES-1:0]              div_done;
   logic [AXES-1:0]              mul_done;
   logic signed [SUM_WIDTH-1:0]  sum_next [AXES];
   logic signed [DIFF_WIDTH-1:0] diff [AXES];
   logic signed [RATE_WIDTH-1:0] div_quot [AXES];
   logic signed [DIFF_WIDTH-1:0] mul_prod [AXES];
   logic signed [DIFF_WIDTH-1:0] bias_sum [AXES];
   logic signed [WIDE_WIDTH-1:0] corr_wide [AXES];
   logic [RATE_WIDTH-1:0]        bias_high [AXES];
   logic [AXES-1:0]              round_up;
   logic signed [RATE_WIDTH-1:0] fixed [AXES];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // stillness judgment from the last odometry item
   always_comb begin
      mag_lin   = last_linear_ff[RATE_WIDTH-1] ? -last_linear_ff : last_linear_ff;
      mag_yaw   = last_yaw_ff[RATE_WIDTH-1] ? -last_yaw_ff : last_yaw_ff;
      still     = (CMP_WIDTH'(mag_lin) < CMP_WIDTH'(lin_limit_ff))
                && (CMP_WIDTH'(mag_yaw) < CMP_WIDTH'(turn_limit_ff));
      if (!still) begin
         run_next = '0;
      end else if (still_run_ff == '1) begin
         run_next = still_run_ff;
      end else begin
         run_next = still_run_ff + 1'b1;
      end
      sampling  = still && (run_next > frames_ff);
      count_inc = sum_count_ff + 1'b1;
      lock_now  = (count_inc == '0) || (count_inc >= lock_count_ff);
      divisor   = (count_inc == '0) ? COUNT_WIDTH'(1) : count_inc;
   end

   // per-axis sums, tracking error, bias update and corrected output
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         sum_next[i]  = sum_ff[i] + {{COUNT_WIDTH{x_ff[i][RATE_WIDTH-1]}}, x_ff[i]};
         diff[i]      = {x_ff[i][RATE_WIDTH-1], x_ff[i], {GAIN_FRACTION{1'b0}}}
                      - {bias_ff[i][BIAS_WIDTH-1], bias_ff[i]};
         bias_sum[i]  = {bias_ff[i][BIAS_WIDTH-1], bias_ff[i]} + mul_prod[i];
         bias_high[i] = bias_ff[i][BIAS_WIDTH-1:GAIN_FRACTION];
         round_up[i]  = (bias_ff[i][GAIN_FRACTION-1:0] > ROUND_HALF);
         corr_wide[i] = {{2{x_ff[i][RATE_WIDTH-1]}}, x_ff[i]}
                      - {{2{bias_high[i][RATE_WIDTH-1]}}, bias_high[i]}
                      - {{(WIDE_WIDTH-1){1'b0}}, round_up[i]};
         if (!locked_ff) begin
            fixed[i] = x_ff[i];
         end else if ((corr_wide[i][WIDE_WIDTH-1:RATE_WIDTH-1] == 3'b000)
                   || (corr_wide[i][WIDE_WIDTH-1:RATE_WIDTH-1] == 3'b111)) begin
            fixed[i] = corr_wide[i][RATE_WIDTH-1:0];
         end else if (corr_wide[i][WIDE_WIDTH-1]) begin
            fixed[i] = RATE_MIN;
         end else begin
            fixed[i] = RATE_MAX;
         end
      end
   end

   // one divider and one multiplier per axis, all lanes run in lockstep
   for (genvar g = 0; g < AXES; g++) begin : g_lane
      gbe_div #(
         .RATE_WIDTH (RATE_WIDTH)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .dividend (sum_next[g]),
         .divisor  (divisor),
         .done     (div_done[g]),
         .quotient (div_quot[g])
      );

      gbe_mul #(
         .RATE_WIDTH    (RATE_WIDTH),
         .GAIN_FRACTION (GAIN_FRACTION)
      ) u_mul (
         .clock   (clock),
         .reset   (reset),
         .start   (mul_start),
         .operand (diff[g]),
         .gain    (gain_ff),
         .done    (mul_done[g]),
         .product (mul_prod[g])
      );
   end

   // sequencer and register writes
   always_comb begin
      state_in       = state_ff;
      lin_limit_in   = lin_limit_ff;
      turn_limit_in  = turn_limit_ff;
      frames_in      = frames_ff;
      lock_count_in  = lock_count_ff;
      gain_in        = gain_ff;
      odo_seen_in    = odo_seen_ff;
      still_run_in   = still_run_ff;
      sum_count_in   = sum_count_ff;
      locked_in      = locked_ff;
      still_in       = still_ff;
      last_linear_in = last_linear_ff;
      last_yaw_in    = last_yaw_ff;
      rsp_locked_in  = rsp_locked_ff;
      rsp_still_in   = rsp_still_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      div_start      = 1'b0;
      mul_start      = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         sum_in[i]       = sum_ff[i];
         x_in[i]         = x_ff[i];
         bias_in[i]      = bias_ff[i];
         rsp_fixed_in[i] = rsp_fixed_ff[i];
      end

      // configuration writes
      if (csr_write) begin
         unique case (csr_index)
            CSR_LINEAR_LIMIT: lin_limit_in  = csr_wdata[LIMIT_WIDTH-1:0];
            CSR_TURN_LIMIT:   turn_limit_in = csr_wdata[LIMIT_WIDTH-1:0];
            CSR_STILL_FRAMES: frames_in     = csr_wdata[FRAMES_WIDTH-1:0];
            CSR_LOCK_COUNT:   lock_count_in = csr_wdata[COUNT_WIDTH-1:0];
            CSR_TRACK_GAIN:   gain_in       = csr_wdata[GAIN_FRACTION-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_ODOMETRY) begin
                  last_linear_in = req_linear_speed;
                  last_yaw_in    = req_yaw_speed;
                  odo_seen_in    = 1'b1;
               end else if (odo_seen_ff) begin
                  x_in[0]  = req_rate_x;
                  x_in[1]  = req_rate_y;
                  x_in[2]  = req_rate_z;
                  state_in = S_JUDGE;
               end
            end
         end
         S_JUDGE: begin
            still_in     = still;
            still_run_in = run_next;
            if (sampling && !locked_ff) begin
               for (int i = 0; i < AXES; i++) begin
                  sum_in[i] = sum_next[i];
               end
               sum_count_in = count_inc;
               if (lock_now) begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end else begin
                  state_in = S_OUT;
               end
            end else if (sampling) begin
               mul_start = 1'b1;
               state_in  = S_MUL;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            // mean becomes the bias with a clear fraction
            if (&div_done) begin
               for (int i = 0; i < AXES; i++) begin
                  bias_in[i] = {div_quot[i], {GAIN_FRACTION{1'b0}}};
               end
               locked_in = 1'b1;
               state_in  = S_OUT;
            end
         end
         S_MUL: begin
            if (&mul_done) begin
               for (int i = 0; i < AXES; i++) begin
                  bias_in[i] = bias_sum[i][BIAS_WIDTH-1:0];
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               for (int i = 0; i < AXES; i++) begin
                  rsp_fixed_in[i] = fixed[i];
               end
               rsp_locked_in = locked_ff;
               rsp_still_in  = still_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state, configuration and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         lin_limit_ff  <= LINEAR_LIMIT_RESET;
         turn_limit_ff <= TURN_LIMIT_RESET;
         frames_ff     <= STILL_FRAMES_RESET;
         lock_count_ff <= LOCK_COUNT_RESET;
         gain_ff       <= TRACK_GAIN_RESET[GAIN_FRACTION-1:0];
         odo_seen_ff   <= 1'b0;
         still_run_ff  <= '0;
         sum_count_ff  <= '0;
         locked_ff     <= 1'b0;
         still_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         lin_limit_ff  <= lin_limit_in;
         turn_limit_ff <= turn_limit_in;
         frames_ff     <= frames_in;
         lock_count_ff <= lock_count_in;
         gain_ff       <= gain_in;
         odo_seen_ff   <= odo_seen_in;
         still_run_ff  <= still_run_in;
         sum_count_ff  <= sum_count_in;
         locked_ff     <= locked_in;
         still_ff      <= still_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int i = 0; i < AXES; i++) begin
            sum_ff[i] <= sum_in[i];
         end
      end
   end

   // item payload, bias and result fields
   always_ff @(posedge clock) begin
      last_linear_ff <= last_linear_in;
      last_yaw_ff    <= last_yaw_in;
      rsp_locked_ff  <= rsp_locked_in;
      rsp_still_ff   <= rsp_still_in;
      for (int i = 0; i < AXES; i++) begin
         x_ff[i]         <= x_in[i];
         bias_ff[i]      <= bias_in[i];
         rsp_fixed_ff[i] <= rsp_fixed_in[i];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fixed_x     = rsp_fixed_ff[0];
   assign rsp_fixed_y     = rsp_fixed_ff[1];
   assign rsp_fixed_z     = rsp_fixed_ff[2];
   assign rsp_bias_locked = rsp_locked_ff;
   assign rsp_is_still    = rsp_still_ff;

endmodule

FILE: dv/tb_gyro_bias_estimator.sv
module tb_gyro_bias_estimator;
   import gbe_pkg::*;

   localparam int     RW            = RATE_WIDTH_DEFAULT;
   localparam int     GF            = GAIN_FRACTION_DEFAULT;
   localparam longint RATE_HI       = (64'sd1 <<< (RW - 1)) - 1;
   localparam longint RATE_LO       = -RATE_HI - 1;
   localparam int unsigned RUN_CEILING = 65535;
   localparam int     SETTLE_CYCLES = 64;
   localparam longint CYCLE_LIMIT   = 4_000_000;
   localparam int     RANDOM_PHASES = 12;
   localparam int     PHASE_ITEMS   = 150;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam logic [CSR_DATA_WIDTH-1:0]  ALL_ONES = '1;

   typedef struct {
      logic                 mode;
      logic signed [RW-1:0] lin;
      logic signed [RW-1:0] yaw;
      logic signed [RW-1:0] rx;
      logic signed [RW-1:0] ry;
      logic signed [RW-1:0] rz;
   } sensor_item_type;

   typedef struct {
      logic signed [RW-1:0] rate [AXES];
      logic                 locked;
      logic                 still;
   } corrected_rate_type;

   // clock, reset and block ports
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_mode = MODE_ODOMETRY;
   logic signed [RW-1:0]         req_linear_speed = '0;
   logic signed [RW-1:0]         req_yaw_speed = '0;
   logic signed [RW-1:0]         req_rate_x = '0;
   logic signed [RW-1:0]         req_rate_y = '0;
   logic signed [RW-1:0]         req_rate_z = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [RW-1:0]         rsp_fixed_x;
   logic signed [RW-1:0]         rsp_fixed_y;
   logic signed [RW-1:0]         rsp_fixed_z;
   logic                         rsp_bias_locked;
   logic                         rsp_is_still;
   logic                         csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]    csr_wdata = '0;

   // expected corrected rates, oldest first
   corrected_rate_type expected_rates [$];
   int              mismatches = 0;
   longint          cycle_count = 0;
   bit              bursts_on = 1'b1;
   int              stall_left = 0;

   // estimator state and register copies
   longint          odo_linear = 0;
   longint          odo_yaw = 0;
   bit              odo_seen = 1'b0;
   int unsigned     still_len = 0;
   longint          sum_acc [AXES] = '{0, 0, 0};
   count_type       sum_cnt = '0;
   bit              bias_ready = 1'b0;
   longint          bias_acc [AXES] = '{0, 0, 0};
   longint          lin_limit = LINEAR_LIMIT_RESET;
   longint          turn_limit = TURN_LIMIT_RESET;
   longint          frames_cfg = STILL_FRAMES_RESET;
   longint          lock_cfg = LOCK_COUNT_RESET;
   longint          gain_cfg = TRACK_GAIN_RESET;

   gyro_bias_estimator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_linear_speed (req_linear_speed),
      .req_yaw_speed    (req_yaw_speed),
      .req_rate_x       (req_rate_x),
      .req_rate_y       (req_rate_y),
      .req_rate_z       (req_rate_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fixed_x      (rsp_fixed_x),
      .rsp_fixed_y      (rsp_fixed_y),
      .rsp_fixed_z      (rsp_fixed_z),
      .rsp_bias_locked  (rsp_bias_locked),
      .rsp_is_still     (rsp_is_still),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver stalls in bursts
   always @(negedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else if (bursts_on && $urandom_range(0, 11) == 0)
         stall_left = $urandom_range(1, 17);
      rsp_stall <= (stall_left > 0);
   end

   // floor(alpha * diff / 2^GF) with a wide product
   function automatic longint track_step(longint diff, longint alpha);
      logic signed [127:0] wide_diff, wide_alpha, prod;
      wide_diff  = diff;
      wide_alpha = alpha;
      prod       = wide_diff * wide_alpha;
      return longint'(prod >>> GF);
   endfunction

   // advance the estimate by one accepted item and queue its corrected rates
   task automatic predict_correction(input sensor_item_type it);
      longint          sample [AXES];
      longint          lin_mag, yaw_mag, n, t;
      bit              still, sampling;
      corrected_rate_type res;
      if (it.mode == MODE_ODOMETRY) begin
         odo_linear = it.lin;
         odo_yaw    = it.yaw;
         odo_seen   = 1'b1;
         return;
      end
      if (!odo_seen)
         return;
      sample[0] = it.rx;
      sample[1] = it.ry;
      sample[2] = it.rz;

      // stillness from the last odometry
      lin_mag = (odo_linear < 0) ? -odo_linear : odo_linear;
      yaw_mag = (odo_yaw < 0) ? -odo_yaw : odo_yaw;
      still = (lin_mag < lin_limit) && (yaw_mag < turn_limit);
      if (still) begin
         if (still_len < RUN_CEILING)
            still_len++;
      end else begin
         still_len = 0;
      end
      sampling = still && (still_len > frames_cfg);

      // initial averaging, then exponential tracking
      if (sampling) begin
         if (!bias_ready) begin
            for (int i = 0; i < AXES; i++)
               sum_acc[i] += sample[i];
            sum_cnt = sum_cnt + 1'b1;
            if (sum_cnt == 0 || sum_cnt >= lock_cfg) begin
               n = (sum_cnt == 0) ? 1 : sum_cnt;
               for (int i = 0; i < AXES; i++)
                  bias_acc[i] = (sum_acc[i] / n) <<< GF;
               bias_ready = 1'b1;
            end
         end else begin
            for (int i = 0; i < AXES; i++)
               bias_acc[i] += track_step((sample[i] <<< GF) - bias_acc[i], gain_cfg);
         end
      end

      // corrected output, rounded and saturated
      for (int i = 0; i < AXES; i++) begin
         t = sample[i];
         if (bias_ready) begin
            t = ((sample[i] <<< GF) - bias_acc[i] + (64'sd1 <<< (GF - 1))) >>> GF;
            if (t > RATE_HI)
               t = RATE_HI;
            else if (t < RATE_LO)
               t = RATE_LO;
         end
         res.rate[i] = RW'(t);
      end
      res.locked = bias_ready;
      res.still  = still;
      expected_rates.push_back(res);
   endtask

   task automatic compare_field(input string name, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result checker
   always @(posedge clock) begin : check_rsp
      corrected_rate_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rates.size() == 0) begin
            $display("%0t: result with nothing expected, got x=%0d y=%0d z=%0d", $time,
                     rsp_fixed_x, rsp_fixed_y, rsp_fixed_z);
            mismatches++;
         end else begin
            want = expected_rates.pop_front();
            compare_field("fixed_x", want.rate[0], rsp_fixed_x);
            compare_field("fixed_y", want.rate[1], rsp_fixed_y);
            compare_field("fixed_z", want.rate[2], rsp_fixed_z);
            compare_field("bias_locked", want.locked, rsp_bias_locked);
            compare_field("is_still", want.still, rsp_is_still);
         end
      end
   end

   // one item on the request channel, with an occasional gap before it
   task automatic send_item(input sensor_item_type it);
      if (bursts_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= it.mode;
      req_linear_speed <= it.lin;
      req_yaw_speed    <= it.yaw;
      req_rate_x       <= it.rx;
      req_rate_y       <= it.ry;
      req_rate_z       <= it.rz;
      do @(posedge clock); while (req_stall);
      predict_correction(it);
      @(negedge clock);
   endtask

   function automatic longint any_rate();
      logic signed [RW-1:0] v;
      v = RW'($urandom);
      return v;
   endfunction

   function automatic longint small_rate();
      return longint'($urandom_range(0, 8191)) - 4096;
   endfunction

   // speed magnitude under the limit, random sign; any rate when the limit is zero
   function automatic longint still_speed(longint limit);
      longint m;
      if (limit == 0)
         return any_rate();
      m = $urandom_range(0, 32'(limit - 1));
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   task automatic send_odometry(input longint lin, input longint yaw);
      sensor_item_type it;
      it.mode = MODE_ODOMETRY;
      it.lin  = RW'(lin);
      it.yaw  = RW'(yaw);
      it.rx   = RW'(any_rate());
      it.ry   = RW'(any_rate());
      it.rz   = RW'(any_rate());
      send_item(it);
   endtask

   task automatic send_gyro(input longint x, input longint y, input longint z);
      sensor_item_type it;
      it.mode = MODE_GYRO;
      it.lin  = RW'(any_rate());
      it.yaw  = RW'(any_rate());
      it.rx   = RW'(x);
      it.ry   = RW'(y);
      it.rz   = RW'(z);
      send_item(it);
   endtask

   // register write, only while the block is idle
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_LINEAR_LIMIT: lin_limit = data[LIMIT_WIDTH-1:0];
         CSR_TURN_LIMIT:   turn_limit = data[LIMIT_WIDTH-1:0];
         CSR_STILL_FRAMES: frames_cfg = data[FRAMES_WIDTH-1:0];
         CSR_LOCK_COUNT:   lock_cfg = data[COUNT_WIDTH-1:0];
         CSR_TRACK_GAIN:   gain_cfg = data & ((64'd1 << GF) - 1);
         default: ;
      endcase
      @(negedge clock);
   endtask

   // hold off until every result is in and the block has gone quiet
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_rates.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // gyro items are dropped until odometry arrives
   task automatic test_gyro_before_odometry();
      send_gyro(RATE_HI, RATE_LO, 0);
      send_gyro(any_rate(), any_rate(), any_rate());
      settle_block();
   endtask

   // strict comparison against the speed limits, pre-lock passthrough
   task automatic test_still_judgement();
      send_odometry(LINEAR_LIMIT_RESET - 1, -(TURN_LIMIT_RESET - 1));
      send_gyro(RATE_HI, RATE_LO, 0);
      send_odometry(LINEAR_LIMIT_RESET, 0);
      send_gyro(-1, 1, RATE_HI);
      send_odometry(0, -TURN_LIMIT_RESET);
      send_gyro(any_rate(), any_rate(), any_rate());
      send_odometry(RATE_LO, RATE_HI);
      send_gyro(RATE_LO, RATE_LO, RATE_LO);
      settle_block();
   endtask

   // zero limits never still, full limits almost always still
   task automatic test_limit_extremes();
      write_csr(CSR_LINEAR_LIMIT, 0);
      write_csr(CSR_TURN_LIMIT, 0);
      write_csr(CSR_SPARE_INDEX, ALL_ONES);
      send_odometry(0, 0);
      send_gyro(any_rate(), any_rate(), any_rate());
      settle_block();
      write_csr(CSR_LINEAR_LIMIT, ALL_ONES);
      write_csr(CSR_TURN_LIMIT, ALL_ONES);
      send_odometry(-(RATE_HI - 1), RATE_HI - 1);
      send_gyro(any_rate(), any_rate(), any_rate());
      settle_block();
   endtask

   // lock count lowered to zero after a few sampled items locks on the next one
   task automatic test_initial_lock();
      write_csr(CSR_LINEAR_LIMIT, LINEAR_LIMIT_RESET);
      write_csr(CSR_TURN_LIMIT, TURN_LIMIT_RESET);
      write_csr(CSR_STILL_FRAMES, 2);
      write_csr(CSR_LOCK_COUNT, ALL_ONES);
      send_odometry(0, 0);
      for (int k = 0; k < 4; k++)
         send_gyro(RATE_HI - k, -3 - (k % 2), RATE_LO + k);
      settle_block();
      write_csr(CSR_LOCK_COUNT, 0);
      send_gyro(RATE_HI - 9, -4, RATE_LO + 3);
      settle_block();
   endtask

   // zero gain holds the bias, full gain follows the sample
   task automatic test_tracking_gain();
      write_csr(CSR_TRACK_GAIN, 0);
      send_gyro(RATE_LO, 0, RATE_HI);
      settle_block();
      write_csr(CSR_TRACK_GAIN, ALL_ONES);
      send_gyro(RATE_LO, RATE_HI, 0);
      settle_block();
   endtask

   task automatic test_still_frames_extremes();
      write_csr(CSR_STILL_FRAMES, 0);
      write_csr(CSR_TRACK_GAIN, TRACK_GAIN_RESET);
      send_gyro(any_rate(), any_rate(), any_rate());
      settle_block();
      write_csr(CSR_STILL_FRAMES, ALL_ONES);
      send_gyro(any_rate(), any_rate(), any_rate());
      settle_block();
   endtask

   // motion clears the run count, tracking resumes only after a new still run
   task automatic test_run_restart();
      write_csr(CSR_STILL_FRAMES, 5);
      write_csr(CSR_TRACK_GAIN, 32'h8000_0000);
      send_odometry(0, 0);
      repeat (8) send_gyro(small_rate(), small_rate(), small_rate());
      send_odometry(RATE_HI, RATE_LO);
      send_gyro(small_rate(), small_rate(), small_rate());
      send_odometry(0, 0);
      repeat (8) send_gyro(small_rate(), small_rate(), small_rate());
      settle_block();
   endtask

   function automatic longint pick_limit();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return RATE_HI;
         5:       return $urandom_range(0, 32'(RATE_HI));
         default: return $urandom_range(1, 20000);
      endcase
   endfunction

   // random settings, then mostly still runs of gyro items with some motion
   task automatic test_random_traffic();
      longint lin, turn, frames, gain;
      int     r;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_block();
         if (phase >= RANDOM_PHASES - 2)
            bursts_on = 1'b0;
         lin  = pick_limit();
         turn = pick_limit();
         case ($urandom_range(0, 9))
            0:       frames = RUN_CEILING;
            1:       frames = $urandom_range(0, RUN_CEILING);
            default: frames = $urandom_range(0, 12);
         endcase
         case ($urandom_range(0, 5))
            0:       gain = 0;
            1:       gain = ALL_ONES;
            2:       gain = $urandom;
            default: gain = $urandom >> $urandom_range(0, 31);
         endcase
         write_csr(CSR_LINEAR_LIMIT, {9'($urandom), LIMIT_WIDTH'(lin)});
         write_csr(CSR_TURN_LIMIT, {9'($urandom), LIMIT_WIDTH'(turn)});
         write_csr(CSR_STILL_FRAMES, {16'($urandom), FRAMES_WIDTH'(frames)});
         write_csr(CSR_LOCK_COUNT, $urandom);
         write_csr(CSR_TRACK_GAIN, CSR_DATA_WIDTH'(gain));
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_INDEX_WIDTH'(CSR_SPARE_INDEX - $urandom_range(0, 2)), $urandom);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 10)
               send_odometry(still_speed(lin_limit), still_speed(turn_limit));
            else if (r < 14)
               send_odometry(any_rate(), any_rate());
            else if (r < 57)
               send_gyro(any_rate(), any_rate(), any_rate());
            else
               send_gyro(small_rate(), small_rate(), small_rate());
         end
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_gyro_before_odometry();
      test_still_judgement();
      test_limit_extremes();
      test_initial_lock();
      test_tracking_gain();
      test_still_frames_extremes();
      test_run_restart();
      test_random_traffic();

      // drain and let any stray result show up
      req_valid <= 1'b0;
      while (expected_rates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_rates.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
